// ===== hdl/fdtsp_pkg.sv =====
package fdtsp_pkg;

  localparam int unsigned DepthWidthDefault = 8;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned DepthOutWidth = 8;
  localparam int unsigned WordsLeftWidth = 30;

  localparam logic [WordWidth-1:0] TokBeginNode = 32'h0000_0001;
  localparam logic [WordWidth-1:0] TokEndNode = 32'h0000_0002;
  localparam logic [WordWidth-1:0] TokProp = 32'h0000_0003;
  localparam logic [WordWidth-1:0] TokNop = 32'h0000_0004;
  localparam logic [WordWidth-1:0] TokEnd = 32'h0000_0009;

  typedef enum logic [2:0] {
    EvNodeBegin = 3'd0,
    EvNodeEnd = 3'd1,
    EvProp = 3'd2,
    EvTreeEnd = 3'd3,
    EvBadToken = 3'd4
  } event_e;

  typedef struct packed {
    event_e event_kind;
    logic [DepthOutWidth-1:0] depth;
    logic [WordWidth-1:0] name_offset;
    logic [WordWidth-1:0] prop_length;
    logic [WordWidth-1:0] prop_value;
  } result_t;

  typedef struct packed {
    logic res_valid;
    logic halted;
  } status_t;

  function automatic logic [WordWidth-1:0] swap32(input logic [WordWidth-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic has_zero_byte(input logic [WordWidth-1:0] v);
    return (v[7:0] == 8'h00) || (v[15:8] == 8'h00) ||
           (v[23:16] == 8'h00) || (v[31:24] == 8'h00);
  endfunction

endpackage

// ===== hdl/fdtsp_parser.sv =====
module fdtsp_parser #(
  parameter int unsigned DEPTH_WIDTH = fdtsp_pkg::DepthWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                word_valid_i,
  input  logic [fdtsp_pkg::WordWidth-1:0]     word_i,
  output fdtsp_pkg::status_t                  status_o,
  output fdtsp_pkg::result_t                  result_o
);

  localparam logic [2:0] PhToken = 3'd0;
  localparam logic [2:0] PhName = 3'd1;
  localparam logic [2:0] PhLen = 3'd2;
  localparam logic [2:0] PhNameOff = 3'd3;
  localparam logic [2:0] PhValue = 3'd4;
  localparam logic [2:0] PhSkip = 3'd5;

  localparam int unsigned WW = fdtsp_pkg::WordWidth;
  localparam int unsigned WLW = fdtsp_pkg::WordsLeftWidth;
  localparam logic [DEPTH_WIDTH-1:0] DepthMax = {DEPTH_WIDTH{1'b1}};

  logic [2:0]             phase_q, phase_d;
  logic [DEPTH_WIDTH-1:0] nest_depth_q, nest_depth_d;
  logic [WLW-1:0]         words_left_q, words_left_d;
  logic [WW-1:0]          held_length_q, held_length_d;
  logic [WW-1:0]          held_name_offset_q, held_name_offset_d;
  logic                   halted_q, halted_d;

  logic [WW-1:0]  w;
  logic [WW:0]    len_round;
  logic [WLW:0]   words_total;
  logic [WLW-1:0] words_m1;
  logic [WLW-1:0] words_dec;
  logic [32:0]    depth_ext;
  logic           res_valid;
  fdtsp_pkg::result_t res;

  assign w = fdtsp_pkg::swap32(word_i);
  assign len_round = {1'b0, held_length_q} + (WW+1)'(3);
  assign words_total = len_round[WW:2];
  assign words_m1 = WLW'(words_total - (WLW+1)'(1));
  assign words_dec = (words_left_q != '0) ? words_left_q - WLW'(1) : words_left_q;
  assign depth_ext = 33'(nest_depth_d);

  always_comb begin
    phase_d = phase_q;
    nest_depth_d = nest_depth_q;
    words_left_d = words_left_q;
    held_length_d = held_length_q;
    held_name_offset_d = held_name_offset_q;
    halted_d = halted_q;
    res_valid = 1'b0;
    res.event_kind = fdtsp_pkg::EvNodeBegin;
    res.name_offset = '0;
    res.prop_length = '0;
    res.prop_value = '0;
    if (word_valid_i && !halted_q) begin
      case (phase_q)
        PhName: begin
          if (fdtsp_pkg::has_zero_byte(word_i)) begin
            phase_d = PhToken;
          end
        end
        PhLen: begin
          held_length_d = w;
          phase_d = PhNameOff;
        end
        PhNameOff: begin
          held_name_offset_d = w;
          if (held_length_q == '0) begin
            phase_d = PhToken;
            res_valid = 1'b1;
            res.event_kind = fdtsp_pkg::EvProp;
            res.name_offset = w;
          end else begin
            phase_d = PhValue;
          end
        end
        PhValue: begin
          words_left_d = words_m1;
          phase_d = (words_m1 != '0) ? PhSkip : PhToken;
          res_valid = 1'b1;
          res.event_kind = fdtsp_pkg::EvProp;
          res.name_offset = held_name_offset_q;
          res.prop_length = held_length_q;
          res.prop_value = w;
        end
        PhSkip: begin
          words_left_d = words_dec;
          if (words_dec == '0) begin
            phase_d = PhToken;
          end
        end
        default: begin
          phase_d = PhToken;
          case (w)
            fdtsp_pkg::TokBeginNode: begin
              if (nest_depth_q != DepthMax) begin
                nest_depth_d = nest_depth_q + DEPTH_WIDTH'(1);
              end
              phase_d = PhName;
              res_valid = 1'b1;
              res.event_kind = fdtsp_pkg::EvNodeBegin;
            end
            fdtsp_pkg::TokEndNode: begin
              if (nest_depth_q != '0) begin
                nest_depth_d = nest_depth_q - DEPTH_WIDTH'(1);
              end
              res_valid = 1'b1;
              res.event_kind = fdtsp_pkg::EvNodeEnd;
            end
            fdtsp_pkg::TokProp: begin
              phase_d = PhLen;
            end
            fdtsp_pkg::TokNop: begin
              phase_d = PhToken;
            end
            fdtsp_pkg::TokEnd: begin
              halted_d = 1'b1;
              res_valid = 1'b1;
              res.event_kind = fdtsp_pkg::EvTreeEnd;
            end
            default: begin
              halted_d = 1'b1;
              res_valid = 1'b1;
              res.event_kind = fdtsp_pkg::EvBadToken;
              res.prop_value = w;
            end
          endcase
        end
      endcase
    end
    res.depth = (depth_ext > 33'd255) ? 8'hff : depth_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhToken;
      nest_depth_q <= '0;
      words_left_q <= '0;
      held_length_q <= '0;
      held_name_offset_q <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      nest_depth_q <= nest_depth_d;
      words_left_q <= words_left_d;
      held_length_q <= held_length_d;
      held_name_offset_q <= held_name_offset_d;
      halted_q <= halted_d;
    end
  end

  assign status_o.res_valid = res_valid;
  assign status_o.halted = halted_q;
  assign result_o = res;

endmodule

// ===== hdl/fdt_structure_token_parser_top.sv =====
// Device tree structure-block parser: takes one raw big-endian word of the
// structure block per request on the s_axis side and issues one event request
// on the m_axis side for node begin, node end, property (on its first value
// word, or on its name-offset word when the length is zero), end of tree and
// bad token; NOP, name and padding words give nothing. A word's event appears
// in the cycle after the word is taken, from a single result register. While
// that event waits unaccepted the input side stalls, so words flow at one per
// clock as long as the m_axis side keeps up. After end of tree or a bad token
// every word is swallowed until reset.
module fdt_structure_token_parser_top #(
  parameter int unsigned DEPTH_WIDTH = fdtsp_pkg::DepthWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // word[31:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // depth[7:0], name_offset[39:8],
                                        // prop_length[71:40], prop_value[103:72]
  output logic [2:0]    m_axis_tuser    // event_kind[2:0]
);

  logic in_accept;
  logic out_valid_q, out_valid_d;
  fdtsp_pkg::status_t status;
  fdtsp_pkg::result_t result;
  fdtsp_pkg::result_t result_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  fdtsp_parser #(
    .DEPTH_WIDTH(DEPTH_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_valid_i(in_accept),
    .word_i      (s_axis_tdata),
    .status_o    (status),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (status.res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.res_valid) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = result_q.event_kind;
  assign m_axis_tdata = {result_q.prop_value, result_q.prop_length,
                         result_q.name_offset, result_q.depth};

`ifndef SYNTHESIS
  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.halted |-> !status.res_valid)
    else $error("event issued while halted");

  a_stop_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_valid && (result.event_kind == fdtsp_pkg::EvTreeEnd ||
                         result.event_kind == fdtsp_pkg::EvBadToken)
    |=> status.halted)
    else $error("end or bad token did not halt");

  a_empty_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_valid && result.event_kind == fdtsp_pkg::EvProp &&
    result.prop_length == '0 |-> result.prop_value == '0)
    else $error("zero-length property carries a value");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_valid |-> in_accept)
    else $error("event without an accepted word");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhToken,
    PhName,
    PhLength,
    PhNameOff,
    PhValue,
    PhSkip
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  parse_phase_e parse_phase = PhToken;
  logic [7:0] nest_level = '0;
  logic [29:0] words_left = '0;
  logic [31:0] held_len = '0;
  logic [31:0] held_noff = '0;
  logic halted = 1'b0;

  fdtsp_pkg::result_t expected_events[$];
  int errors = 0;
  int unsigned words_sent = 0;
  bit feed_idle = 1'b1;
  bit drain_idle = 1'b1;
  int unsigned drain_hold = 0;

  fdt_structure_token_parser_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic has_nul(input logic [31:0] v);
    return v[7:0] == 8'h00 || v[15:8] == 8'h00 || v[23:16] == 8'h00 || v[31:24] == 8'h00;
  endfunction

  function automatic void parse_word(input logic [31:0] raw);
    logic [31:0] w;
    logic [32:0] n_words;
    logic emit;
    fdtsp_pkg::result_t ev;
    if (halted) return;
    w = swap_bytes(raw);
    ev = '0;
    emit = 1'b0;
    case (parse_phase)
      PhName: begin
        if (has_nul(raw)) parse_phase = PhToken;
      end
      PhLength: begin
        held_len = w;
        parse_phase = PhNameOff;
      end
      PhNameOff: begin
        held_noff = w;
        if (held_len == 0) begin
          parse_phase = PhToken;
          ev.event_kind = fdtsp_pkg::EvProp;
          ev.name_offset = w;
          emit = 1'b1;
        end else begin
          parse_phase = PhValue;
        end
      end
      PhValue: begin
        n_words = ({1'b0, held_len} + 33'd3) >> 2;
        words_left = 30'(n_words - 33'd1);
        parse_phase = (words_left != 0) ? PhSkip : PhToken;
        ev.event_kind = fdtsp_pkg::EvProp;
        ev.name_offset = held_noff;
        ev.prop_length = held_len;
        ev.prop_value = w;
        emit = 1'b1;
      end
      PhSkip: begin
        if (words_left != 0) words_left = words_left - 30'd1;
        if (words_left == 0) parse_phase = PhToken;
      end
      default: begin
        parse_phase = PhToken;
        if (w == fdtsp_pkg::TokBeginNode) begin
          if (nest_level != 8'hff) nest_level = nest_level + 8'd1;
          parse_phase = PhName;
          ev.event_kind = fdtsp_pkg::EvNodeBegin;
          emit = 1'b1;
        end else if (w == fdtsp_pkg::TokEndNode) begin
          if (nest_level != 0) nest_level = nest_level - 8'd1;
          ev.event_kind = fdtsp_pkg::EvNodeEnd;
          emit = 1'b1;
        end else if (w == fdtsp_pkg::TokProp) begin
          parse_phase = PhLength;
        end else if (w != fdtsp_pkg::TokNop) begin
          halted = 1'b1;
          ev.event_kind = (w == fdtsp_pkg::TokEnd) ? fdtsp_pkg::EvTreeEnd
                                                   : fdtsp_pkg::EvBadToken;
          ev.prop_value = (w == fdtsp_pkg::TokEnd) ? 32'h0 : w;
          emit = 1'b1;
        end
      end
    endcase
    if (emit) begin
      ev.depth = nest_level;
      expected_events.push_back(ev);
    end
  endfunction

  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    gap = feed_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_word(w);
    words_sent++;
  endtask

  task automatic send_token(input logic [31:0] tok);
    send_word(swap_bytes(tok));
  endtask

  function automatic logic [31:0] name_fill();
    return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
  endfunction

  function automatic logic [31:0] name_tail();
    logic [31:0] w;
    w = $urandom();
    w[8 * $urandom_range(0, 3) +: 8] = 8'h00;
    return w;
  endfunction

  function automatic logic [31:0] payload_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return swap_bytes($urandom_range(0, 1) ? fdtsp_pkg::TokEnd
                                                : 32'($urandom_range(0, 15)));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_node_begin(input int unsigned name_words);
    send_token(fdtsp_pkg::TokBeginNode);
    repeat (name_words - 1) send_word(name_fill());
    send_word(name_tail());
  endtask

  task automatic send_prop(input logic [31:0] len, input logic [31:0] noff);
    send_token(fdtsp_pkg::TokProp);
    send_word(swap_bytes(len));
    send_word(swap_bytes(noff));
    for (int unsigned i = 0; i < (len + 3) / 4; i++) send_word(payload_word());
  endtask

  task automatic test_basic_tokens();
    send_token(fdtsp_pkg::TokNop);
    send_token(fdtsp_pkg::TokEndNode);
    send_token(fdtsp_pkg::TokBeginNode);
    send_word(32'h0);
    send_prop(32'd0, 32'hffff_ffff);
    send_prop(32'd1, 32'd0);
    send_prop(32'd4, 32'h8000_0001);
    send_prop(32'd5, 32'h0000_0024);
    send_node_begin(3);
    send_token(fdtsp_pkg::TokNop);
    send_token(fdtsp_pkg::TokEndNode);
    send_token(fdtsp_pkg::TokEndNode);
  endtask

  task automatic test_depth_saturation();
    feed_idle = 1'b0;
    repeat (256) send_node_begin(1);
    feed_idle = 1'b1;
    repeat (2) send_token(fdtsp_pkg::TokEndNode);
  endtask

  task automatic test_output_backpressure();
    feed_idle = 1'b0;
    drain_idle = 1'b0;
    drain_hold = 200;
    send_node_begin(1);
    repeat (3) begin
      send_node_begin(1);
      send_token(fdtsp_pkg::TokEndNode);
    end
    feed_idle = 1'b1;
    drain_idle = 1'b1;
  endtask

  task automatic test_random_tree(input int unsigned n);
    int unsigned stop_at;
    int unsigned next_mix;
    int unsigned toss;
    logic [31:0] len;
    stop_at = words_sent + n;
    next_mix = words_sent;
    while (words_sent < stop_at) begin
      if (words_sent >= next_mix) begin
        feed_idle = $urandom_range(0, 3) != 0;
        drain_idle = $urandom_range(0, 3) != 0;
        next_mix = words_sent + 40;
      end
      toss = $urandom_range(0, 99);
      if (nest_level > 12 && toss < 30) toss = toss + 30;
      if (toss < 30) begin
        send_node_begin($urandom_range(1, 3));
      end else if (toss < 55) begin
        send_token(fdtsp_pkg::TokEndNode);
      end else if (toss < 88) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        send_prop(len, $urandom());
      end else begin
        send_token(fdtsp_pkg::TokNop);
      end
    end
    feed_idle = 1'b1;
    drain_idle = 1'b1;
  endtask

  task automatic test_stream_stop();
    logic [31:0] tok;
    case ($urandom_range(0, 2))
      0: send_token(fdtsp_pkg::TokEnd);
      1: begin
        do begin
          tok = $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : 32'($urandom());
        end while (tok == fdtsp_pkg::TokBeginNode || tok == fdtsp_pkg::TokEndNode ||
                   tok == fdtsp_pkg::TokProp || tok == fdtsp_pkg::TokNop ||
                   tok == fdtsp_pkg::TokEnd);
        send_token(tok);
      end
      default: begin
        send_token(fdtsp_pkg::TokProp);
        send_word(swap_bytes(32'hffff_ffff - 32'($urandom_range(0, 3))));
        send_word($urandom());
      end
    endcase
    repeat (6) send_word(payload_word());
    send_token(fdtsp_pkg::TokBeginNode);
    send_token(fdtsp_pkg::TokEndNode);
  endtask

  always @(posedge clk_i) begin
    fdtsp_pkg::result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d data %h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tuser !== want.event_kind) begin
          $error("event_kind: expected %0d, actual %0d", want.event_kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[7:0] !== want.depth) begin
          $error("depth: expected %0d, actual %0d", want.depth, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[39:8] !== want.name_offset) begin
          $error("name_offset: expected %h, actual %h", want.name_offset, m_axis_tdata[39:8]);
          errors++;
        end
        if (m_axis_tdata[71:40] !== want.prop_length) begin
          $error("prop_length: expected %h, actual %h", want.prop_length, m_axis_tdata[71:40]);
          errors++;
        end
        if (m_axis_tdata[103:72] !== want.prop_value) begin
          $error("prop_value: expected %h, actual %h", want.prop_value, m_axis_tdata[103:72]);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (drain_hold != 0) begin
        stall = drain_hold;
        drain_hold = 0;
      end else begin
        stall = drain_idle ? $urandom_range(0, 6) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_tokens();
    test_depth_saturation();
    test_output_backpressure();
    test_random_tree(40);
    test_stream_stop();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== fdt_structure_token_parser_top.f =====
hdl/fdtsp_pkg.sv
hdl/fdtsp_parser.sv
hdl/fdt_structure_token_parser_top.sv
tb/sv/testbench.sv
